### src/sme_pkg.sv
// Package for the stack machine execute block: word types, opcodes, error codes.
// No dependencies.
`timescale 1ns / 1ps
package sme_pkg;

  typedef struct packed {
    logic [7:0]         func;
    logic signed [23:0] immediate;
    logic signed [31:0] read_value;
  } sme_in_t;

  typedef struct packed {
    logic [23:0]        next_pc;
    logic               halted;
    logic               out_valid;
    logic               out_is_char;
    logic signed [31:0] out_value;
    logic [2:0]         error_code;
  } sme_out_t;

  localparam logic [7:0] OP_HALT = 8'd0,  OP_PUSHC = 8'd1,  OP_ADD = 8'd2,  OP_SUB = 8'd3;
  localparam logic [7:0] OP_MUL = 8'd4,   OP_DIV = 8'd5,    OP_MOD = 8'd6,  OP_RDINT = 8'd7;
  localparam logic [7:0] OP_WRINT = 8'd8, OP_RDCHR = 8'd9,  OP_WRCHR = 8'd10;
  localparam logic [7:0] OP_PUSHG = 8'd11, OP_POPG = 8'd12, OP_ASF = 8'd13, OP_RSF = 8'd14;
  localparam logic [7:0] OP_PUSHL = 8'd15, OP_POPL = 8'd16, OP_EQ = 8'd17, OP_NE = 8'd18;
  localparam logic [7:0] OP_LT = 8'd19, OP_LE = 8'd20, OP_GT = 8'd21, OP_GE = 8'd22;
  localparam logic [7:0] OP_JMP = 8'd23, OP_BRF = 8'd24, OP_BRT = 8'd25, OP_CALL = 8'd26;
  localparam logic [7:0] OP_RET = 8'd27, OP_DROP = 8'd28, OP_PUSHR = 8'd29, OP_POPR = 8'd30;
  localparam logic [7:0] OP_DUP = 8'd31;

  localparam logic [2:0] ERR_NONE = 3'd0, ERR_OVER = 3'd1, ERR_UNDER = 3'd2, ERR_DIV0 = 3'd3;
  localparam logic [2:0] ERR_GIDX = 3'd4, ERR_LIDX = 3'd5, ERR_BADOP = 3'd6;

  localparam logic [31:0] IMM_EXT = 32'hFF00_0000;

  // classification attached by the front end
  typedef struct packed {
    logic pops2;    // binary arithmetic/compare
    logic is_div;   // div or mod
    logic bad_op;
  } sme_cls_t;

  typedef struct packed {
    sme_in_t  word;
    sme_cls_t cls;
  } sme_q_t;

endpackage

### src/sme_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### src/sme_front.sv
// Front end: accepts instruction words, classifies, and queues them (two entries).
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_front import sme_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sme_in_t in_word,
  output logic    q_valid,
  input  logic    q_pop,
  output sme_q_t  q_head
);
  sme_q_t     ent_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  sme_q_t     new_q;
  logic       push;

  always_comb begin
    new_q.word = in_word;
    new_q.cls.pops2 = (in_word.func >= OP_ADD && in_word.func <= OP_MOD) ||
                      (in_word.func >= OP_EQ && in_word.func <= OP_GE);
    new_q.cls.is_div = in_word.func == OP_DIV || in_word.func == OP_MOD;
    new_q.cls.bad_op = in_word.func > OP_DUP;
  end

  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_head   = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= new_q;
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

### src/sme_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module sme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  logic [31:0] q_r, r_r, d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};
  assign quot = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; cnt_r <= 6'd32;
        q_r <= dividend; r_r <= '0; d_r <= divisor;
      end else if (busy_r) begin
        if (!trial[32]) r_r <= trial[31:0];
        else            r_r <= {r_r[30:0], q_r[31]};
        q_r <= {q_r[30:0], ~trial[32]};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

### src/sme_back.sv
// Back end: sequencer that executes one queued instruction against the stack and
// global memories. Depends on sme_pkg, sme_ram, sme_div.
`timescale 1ns / 1ps
module sme_back import sme_pkg::*; #(
  parameter int STACK_DEPTH  = 1024,
  parameter int GLOBAL_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [8:0] static_count,
  input  logic     q_valid,
  output logic     q_pop,
  input  sme_q_t   q_head,
  output logic     out_valid,
  input  logic     out_ready,
  output sme_out_t out_word
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = SAW + 1;
  localparam int GAW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam logic [SPW-1:0] SDEP = SPW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RDB, S_RDA, S_RDX, S_DIV, S_EXEC, S_OUT
  } state_t;

  state_t       state_r;
  logic [SPW-1:0] sp_r, fp_r;
  logic [23:0]  pc_r;
  logic [31:0]  rv_r;
  logic         halt_r;
  logic [31:0]  a_r, b_r, x_r;
  sme_out_t     res_r;

  // stack RAM port: operand reads, or the execute write in S_EXEC
  logic             s_we_f;
  logic [SAW-1:0]   s_addr, s_addr_f;
  logic [31:0]      s_wdata_f, s_rdata;
  logic             g_we_f;
  logic [GAW-1:0]   g_addr;
  logic [31:0]      g_rdata;

  // decoded fields of the head word
  logic [7:0]  op;
  logic [31:0] imm32;
  logic signed [SPW+24:0] simm, laddr, faddr;
  logic        gidx_bad;
  logic [SPW-1:0] sp_m1, sp_m2, sp_p1;

  assign op    = q_head.word.func;
  assign imm32 = {{8{q_head.word.immediate[23]}}, q_head.word.immediate};
  assign simm  = (SPW+25)'(q_head.word.immediate);
  assign laddr = $signed({25'd0, fp_r}) + simm;
  assign faddr = $signed({25'd0, sp_r}) + (SPW+25)'(1) + simm;
  assign gidx_bad = q_head.word.immediate[23] ||
                    (q_head.word.immediate >= $signed({15'd0, static_count})) ||
                    (q_head.word.immediate >= 24'(GLOBAL_DEPTH));
  assign sp_m1 = sp_r - 1'b1;
  assign sp_m2 = sp_r - SPW'(2);
  assign sp_p1 = sp_r + 1'b1;
  assign g_addr = q_head.word.immediate[GAW-1:0];

  // divider on magnitudes
  logic        div_start, div_done;
  logic [31:0] div_q, div_r, mag_a, mag_b;
  assign mag_a = a_r[31] ? -a_r : a_r;
  assign mag_b = b_r[31] ? -b_r : b_r;
  sme_div u_div (.clk, .rst_n, .start(div_start), .dividend(mag_a), .divisor(mag_b),
                 .done(div_done), .quot(div_q), .rem(div_r));

  logic [31:0] prod_r;

  // operand read address
  always_comb begin
    s_addr = sp_m1[SAW-1:0];
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: s_addr = sp_m1[SAW-1:0];
      S_RDB: begin
        s_addr = sp_m2[SAW-1:0];
        if (op == OP_RSF) s_addr = SAW'(fp_r - 1'b1);
        else if (op == OP_PUSHL) s_addr = laddr[SAW-1:0];
      end
      S_RDA: s_addr = sp_m2[SAW-1:0];
      S_RDX: s_addr = sp_m2[SAW-1:0];
      S_DIV: s_addr = sp_m2[SAW-1:0];
      S_EXEC: s_addr = sp_m2[SAW-1:0];
      S_OUT: s_addr = sp_m2[SAW-1:0];
      default: ;
    endcase
    if (state_r == S_RDX && q_head.cls.is_div && b_r != 0 && sp_r >= SPW'(2))
      div_start = 1'b1;
  end

  // execute: computed combinationally in S_EXEC from latched operands
  logic [2:0]  err;
  logic [SPW-1:0] sp_n, fp_n;
  logic [23:0] pc_n;
  logic [31:0] rv_n;
  logic        halt_n, ov, ochr;
  logic [31:0] oval, r;
  logic        sw; logic [SAW-1:0] sa; logic [31:0] sd;
  logic        gw;

  always_comb begin
    err = ERR_NONE; sp_n = sp_r; fp_n = fp_r; pc_n = pc_r + 24'd1; rv_n = rv_r;
    halt_n = halt_r; ov = 1'b0; ochr = 1'b0; oval = '0; r = '0;
    sw = 1'b0; sa = sp_r[SAW-1:0]; sd = '0; gw = 1'b0;
    unique case (op)
      OP_ADD: r = a_r + b_r;
      OP_SUB: r = a_r - b_r;
      OP_MUL: r = prod_r;
      OP_DIV: r = (a_r[31] ^ b_r[31]) ? -div_q : div_q;
      OP_MOD: r = a_r[31] ? -div_r : div_r;
      OP_EQ:  r = {31'd0, a_r == b_r};
      OP_NE:  r = {31'd0, a_r != b_r};
      OP_LT:  r = {31'd0, $signed(a_r) < $signed(b_r)};
      OP_LE:  r = {31'd0, $signed(a_r) <= $signed(b_r)};
      OP_GT:  r = {31'd0, $signed(a_r) > $signed(b_r)};
      OP_GE:  r = {31'd0, $signed(a_r) >= $signed(b_r)};
      default: r = '0;
    endcase
    if (q_head.cls.bad_op) err = ERR_BADOP;
    else if (q_head.cls.pops2) begin
      if (sp_r < SPW'(2)) err = ERR_UNDER;
      else if (q_head.cls.is_div && b_r == 0) err = ERR_DIV0;
      else begin
        sw = 1'b1; sa = sp_m2[SAW-1:0]; sd = r; sp_n = sp_m1;
      end
    end else begin
      unique case (op)
        OP_HALT: halt_n = 1'b1;
        OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR: begin
          if (sp_r >= SDEP) err = ERR_OVER;
          else begin
            sw = 1'b1; sp_n = sp_p1;
            sd = (op == OP_PUSHC) ? imm32 :
                 (op == OP_RDINT) ? q_head.word.read_value :
                 (op == OP_RDCHR) ? {24'd0, q_head.word.read_value[7:0]} : rv_r;
          end
        end
        OP_WRINT, OP_WRCHR: begin
          if (sp_r == 0) err = ERR_UNDER;
          else begin
            ov = 1'b1; ochr = op == OP_WRCHR;
            oval = ochr ? {24'd0, b_r[7:0]} : b_r; sp_n = sp_m1;
          end
        end
        OP_PUSHG: begin
          if (sp_r >= SDEP) err = ERR_OVER;
          else if (gidx_bad) err = ERR_GIDX;
          else begin sw = 1'b1; sd = x_r; sp_n = sp_p1; end
        end
        OP_POPG: begin
          if (sp_r == 0) err = ERR_UNDER;
          else if (gidx_bad) err = ERR_GIDX;
          else begin gw = 1'b1; sp_n = sp_m1; end
        end
        OP_ASF: begin
          if (sp_r >= SDEP) err = ERR_OVER;
          else if (faddr < 0) err = ERR_UNDER;
          else if (faddr > $signed({25'd0, SDEP})) err = ERR_OVER;
          else begin
            sw = 1'b1; sd = 32'(fp_r); fp_n = sp_p1; sp_n = faddr[SPW-1:0];
          end
        end
        OP_RSF: begin
          if (fp_r == 0) err = ERR_UNDER;
          else if (x_r > 32'(STACK_DEPTH)) err = ERR_LIDX;
          else begin sp_n = fp_r - 1'b1; fp_n = x_r[SPW-1:0]; end
        end
        OP_PUSHL: begin
          if (sp_r >= SDEP) err = ERR_OVER;
          else if (laddr < 0 || laddr >= $signed({25'd0, SDEP})) err = ERR_LIDX;
          else begin sw = 1'b1; sd = x_r; sp_n = sp_p1; end
        end
        OP_POPL: begin
          if (sp_r == 0) err = ERR_UNDER;
          else if (laddr < 0 || laddr >= $signed({25'd0, SDEP})) err = ERR_LIDX;
          else begin sw = 1'b1; sa = laddr[SAW-1:0]; sd = b_r; sp_n = sp_m1; end
        end
        OP_JMP: pc_n = imm32[23:0];
        OP_BRF, OP_BRT: begin
          if (sp_r == 0) err = ERR_UNDER;
          else begin
            sp_n = sp_m1;
            if ((op == OP_BRF && b_r == 0) || (op == OP_BRT && b_r == 32'd1))
              pc_n = imm32[23:0];
          end
        end
        OP_CALL: begin
          if (sp_r >= SDEP) err = ERR_OVER;
          else begin
            sw = 1'b1; sd = {8'd0, pc_r + 24'd1}; sp_n = sp_p1; pc_n = imm32[23:0];
          end
        end
        OP_RET: begin
          if (sp_r == 0) err = ERR_UNDER;
          else begin pc_n = b_r[23:0]; sp_n = sp_m1; end
        end
        OP_DROP: begin
          if (!q_head.word.immediate[23] && q_head.word.immediate != 0) begin
            if (simm > $signed({25'd0, sp_r})) err = ERR_UNDER;
            else sp_n = sp_r - simm[SPW-1:0];
          end
        end
        OP_POPR: begin
          if (sp_r == 0) err = ERR_UNDER;
          else begin rv_n = b_r; sp_n = sp_m1; end
        end
        OP_DUP: begin
          if (sp_r == 0) err = ERR_UNDER;
          else if (sp_r >= SDEP) err = ERR_OVER;
          else begin sw = 1'b1; sd = b_r; sp_n = sp_p1; end
        end
        default: ;
      endcase
    end
    if (err != ERR_NONE) begin
      sw = 1'b0; gw = 1'b0; sp_n = sp_r; fp_n = fp_r; rv_n = rv_r; halt_n = 1'b1;
      ov = 1'b0; ochr = 1'b0; oval = '0;
    end
  end

  logic exec_go;
  assign exec_go = state_r == S_EXEC;

  // merge execute writes onto the RAM ports
  always_comb begin
    s_addr_f  = exec_go ? sa : s_addr;
    s_we_f    = exec_go && sw;
    s_wdata_f = sd;
    g_we_f    = exec_go && gw;
  end

  sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(s_we_f), .addr(s_addr_f), .wdata(s_wdata_f), .rdata(s_rdata));
  sme_ram #(.WIDTH(32), .DEPTH((GLOBAL_DEPTH > 1) ? GLOBAL_DEPTH : 2)) u_glob (
    .clk, .we(g_we_f), .addr(g_addr), .wdata(b_r), .rdata(g_rdata));

  assign q_pop     = (state_r == S_IDLE && q_valid && halt_r) || exec_go;
  assign out_valid = state_r == S_OUT;
  assign out_word  = res_r;

  always_ff @(posedge clk) begin
    prod_r <= a_r * b_r;
    if (state_r == S_RDB) b_r <= s_rdata;
    if (state_r == S_RDA) begin
      // a_r is only used by two-operand ops; x_r carries the other loads
      a_r <= s_rdata;
      x_r <= (op == OP_PUSHG) ? g_rdata : s_rdata;
    end
    if (!rst_n) begin
      state_r <= S_IDLE; sp_r <= '0; fp_r <= '0; pc_r <= '0; rv_r <= '0; halt_r <= 1'b0;
      res_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          if (halt_r) begin
            res_r <= '{next_pc: pc_r, halted: 1'b1, out_valid: 1'b0, out_is_char: 1'b0,
                       out_value: '0, error_code: ERR_NONE};
            state_r <= S_OUT;
          end else state_r <= S_RDB;
        end
        S_RDB: state_r <= S_RDA;
        S_RDA: state_r <= S_RDX;
        S_RDX: state_r <= q_head.cls.is_div && b_r != 0 && sp_r >= SPW'(2) ? S_DIV : S_EXEC;
        S_DIV: if (div_done) state_r <= S_EXEC;
        S_EXEC: begin
          sp_r <= sp_n; fp_r <= fp_n; pc_r <= pc_n; rv_r <= rv_n; halt_r <= halt_n;
          res_r <= '{next_pc: pc_n, halted: halt_n, out_valid: ov, out_is_char: ochr,
                     out_value: oval, error_code: err};
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### src/stack_machine_execute.sv
// Top level of the stack machine execute block: front queue plus execution back end.
// Depends on sme_pkg, sme_front, sme_back.
`timescale 1ns / 1ps
// The back end finishes each word before it starts the next; div/mod also wait on the
// bit-serial divider, and a halted machine answers without reading operands.
// The back-end sequencer reads two stack entries through the single-port stack RAM,
// then executes and holds the result word until it is taken.
// Reset (rst_n low, synchronous): sp, fp, pc, return value, halt flag and static_count
// clear; the stack and global memories are not cleared.
module stack_machine_execute import sme_pkg::*; #(
  parameter int STACK_DEPTH  = 1024,
  parameter int GLOBAL_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sme_in_t  in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output sme_out_t out_word,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [8:0] cfg_static_count
);
  logic [8:0] static_count_r;
  logic       q_valid, q_pop;
  sme_q_t     q_head;

  // config is always accepted; software writes it only while idle
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) static_count_r <= '0;
    else if (cfg_valid) static_count_r <= cfg_static_count;
  end

  // front: accepts and classifies words into a two-deep queue
  sme_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .q_valid, .q_pop, .q_head);

  // back: reads operands, executes, holds the result word until taken
  sme_back #(.STACK_DEPTH(STACK_DEPTH), .GLOBAL_DEPTH(GLOBAL_DEPTH)) u_back (
    .clk, .rst_n, .static_count(static_count_r),
    .q_valid, .q_pop, .q_head, .out_valid, .out_ready, .out_word);
endmodule

### tb/tb_stack_machine_execute.sv
// Self-checking testbench for stack_machine_execute: directed programs plus random legal streams.
// Depends on sme_pkg and the stack_machine_execute RTL.
`timescale 1ns / 1ps
module tb_stack_machine_execute;
  import sme_pkg::*;

  localparam int STK = 1024;
  localparam int GLB = 256;
  localparam int STALL_LIMIT = 4000;  // cycles with no accepted word on any channel
  localparam int DRAIN_WAIT = 60;     // quiet gap between phases

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sme_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sme_out_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_static_count = '0;

  stack_machine_execute #(.STACK_DEPTH(STK), .GLOBAL_DEPTH(GLB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_static_count(cfg_static_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Machine image kept by the testbench
  // ---------------------------------------------------------------------------
  logic [31:0] stk_mem [STK];
  logic [31:0] glb_mem [GLB];
  int          m_sp, m_fp;
  logic [23:0] m_pc;
  logic [31:0] m_rv;
  logic        m_halt;
  int          m_count;       // static_count as last written

  sme_out_t    pending_q[$];  // expected result words, oldest first
  int          n_fail, n_words, n_results, n_writes, n_cfg;
  bit          idle_en = 1'b1;

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Executes one instruction on the image and returns the result word it gives.
  function automatic sme_out_t exec_word(sme_in_t w);
    sme_out_t    r;
    logic [31:0] a, b, imm, q, res;
    longint      simm, addr;
    logic [2:0]  e;
    int          s;
    r = '0;
    if (m_halt) begin
      r.next_pc = m_pc;
      r.halted = 1'b1;
      return r;
    end
    imm = {{8{w.immediate[23]}}, w.immediate};
    simm = longint'(w.immediate);
    s = m_sp;
    a = '0;
    b = '0;
    res = '0;
    e = ERR_NONE;
    m_pc = m_pc + 24'd1;
    if (s >= 1) b = stk_mem[s-1];
    if (s >= 2) a = stk_mem[s-2];
    case (w.func)
      OP_HALT: m_halt = 1'b1;
      OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR: begin
        if (s >= STK) e = ERR_OVER;
        else begin
          stk_mem[s] = (w.func == OP_PUSHC) ? imm :
                       (w.func == OP_RDINT) ? w.read_value :
                       (w.func == OP_RDCHR) ? {24'd0, w.read_value[7:0]} : m_rv;
          m_sp = s + 1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        if (s < 2) e = ERR_UNDER;
        else if ((w.func == OP_DIV || w.func == OP_MOD) && b == 0) e = ERR_DIV0;
        else begin
          case (w.func)
            OP_ADD: res = a + b;
            OP_SUB: res = a - b;
            OP_MUL: res = a * b;
            OP_DIV: begin
              q = mag(a) / mag(b);
              res = (a[31] ^ b[31]) ? (32'd0 - q) : q;
            end
            OP_MOD: begin
              q = mag(a) % mag(b);
              res = a[31] ? (32'd0 - q) : q;
            end
            OP_EQ: res = 32'(a == b);
            OP_NE: res = 32'(a != b);
            OP_LT: res = 32'($signed(a) < $signed(b));
            OP_LE: res = 32'($signed(a) <= $signed(b));
            OP_GT: res = 32'($signed(a) > $signed(b));
            default: res = 32'($signed(a) >= $signed(b));
          endcase
          stk_mem[s-2] = res;
          m_sp = s - 1;
        end
      end
      OP_WRINT, OP_WRCHR: begin
        if (s < 1) e = ERR_UNDER;
        else begin
          r.out_valid = 1'b1;
          r.out_is_char = (w.func == OP_WRCHR);
          r.out_value = r.out_is_char ? {24'd0, b[7:0]} : b;
          m_sp = s - 1;
        end
      end
      OP_PUSHG: begin
        if (s >= STK) e = ERR_OVER;
        else if (simm < 0 || simm >= m_count || simm >= GLB) e = ERR_GIDX;
        else begin
          stk_mem[s] = glb_mem[simm];
          m_sp = s + 1;
        end
      end
      OP_POPG: begin
        if (s < 1) e = ERR_UNDER;
        else if (simm < 0 || simm >= m_count || simm >= GLB) e = ERR_GIDX;
        else begin
          glb_mem[simm] = b;
          m_sp = s - 1;
        end
      end
      OP_ASF: begin
        addr = longint'(s) + 1 + simm;
        if (s >= STK) e = ERR_OVER;
        else if (addr < 0) e = ERR_UNDER;
        else if (addr > STK) e = ERR_OVER;
        else begin
          stk_mem[s] = 32'(m_fp);
          m_fp = s + 1;
          m_sp = int'(addr);
        end
      end
      OP_RSF: begin
        if (m_fp < 1) e = ERR_UNDER;
        else if (stk_mem[m_fp-1] > STK) e = ERR_LIDX;
        else begin
          m_sp = m_fp - 1;
          m_fp = int'(stk_mem[m_fp-1]);
        end
      end
      OP_PUSHL, OP_POPL: begin
        addr = longint'(m_fp) + simm;
        if (w.func == OP_PUSHL && s >= STK) e = ERR_OVER;
        else if (w.func == OP_POPL && s < 1) e = ERR_UNDER;
        else if (addr < 0 || addr >= STK) e = ERR_LIDX;
        else if (w.func == OP_PUSHL) begin
          stk_mem[s] = stk_mem[addr];
          m_sp = s + 1;
        end else begin
          stk_mem[addr] = b;
          m_sp = s - 1;
        end
      end
      OP_JMP: m_pc = imm[23:0];
      OP_BRF, OP_BRT: begin
        if (s < 1) e = ERR_UNDER;
        else begin
          if ((w.func == OP_BRF && b == 0) || (w.func == OP_BRT && b == 1)) m_pc = imm[23:0];
          m_sp = s - 1;
        end
      end
      OP_CALL: begin
        if (s >= STK) e = ERR_OVER;
        else begin
          stk_mem[s] = {8'd0, m_pc};
          m_sp = s + 1;
          m_pc = imm[23:0];
        end
      end
      OP_RET: begin
        if (s < 1) e = ERR_UNDER;
        else begin
          m_pc = b[23:0];
          m_sp = s - 1;
        end
      end
      OP_DROP: begin
        if (simm > 0) begin
          if (simm > s) e = ERR_UNDER;
          else m_sp = s - int'(simm);
        end
      end
      OP_POPR: begin
        if (s < 1) e = ERR_UNDER;
        else begin
          m_rv = b;
          m_sp = s - 1;
        end
      end
      OP_DUP: begin
        if (s < 1) e = ERR_UNDER;
        else if (s >= STK) e = ERR_OVER;
        else begin
          stk_mem[s] = b;
          m_sp = s + 1;
        end
      end
      default: e = ERR_BADOP;
    endcase
    if (e != ERR_NONE) begin
      m_halt = 1'b1;
      r.out_valid = 1'b0;
      r.out_is_char = 1'b0;
      r.out_value = '0;
    end
    r.next_pc = m_pc;
    r.halted = m_halt;
    r.error_code = e;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Ready is sampled at the falling edge; the word moves at the next
  // rising edge, where the next word may be driven in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_word(sme_in_t w);
    bit took;
    if (idle_en && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    pending_q.push_back(exec_word(w));
    n_words++;
  endtask

  task automatic send_op(logic [7:0] op, int imm = 0, logic [31:0] rd = 32'd0);
    sme_in_t w;
    w.func = op;
    w.immediate = 24'(imm);
    w.read_value = rd;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);  // idle gap before the next phase
  endtask

  task automatic write_static_count(int v);
    bit took;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_static_count <= 9'(v);
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    m_count = v;
    n_cfg++;
  endtask

  // Result side stalls at random too; in the quiet stretch it always takes.
  always @(posedge clk) out_ready <= !idle_en || ($urandom_range(99) >= 15);

  function automatic void chk(string fname, longint expv, longint actv);
    if (expv != actv) begin
      $error("%s: expected %0h, got %0h", fname, expv, actv);
      n_fail++;
    end
  endfunction

  always @(negedge clk) begin
    sme_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected: next_pc %0h", out_word.next_pc);
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        chk("next_pc", want.next_pc, out_word.next_pc);
        chk("halted", want.halted, out_word.halted);
        chk("out_valid", want.out_valid, out_word.out_valid);
        chk("out_is_char", want.out_is_char, out_word.out_is_char);
        chk("out_value", want.out_value, out_word.out_value);
        chk("error_code", want.error_code, out_word.error_code);
        if (want.out_valid) n_writes++;
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  int quiet_cycles = 0;
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("stack_machine_execute verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Fill every stack slot and every global once so that no later read ever
  // touches a never-written entry, then empty the stack again.
  task automatic test_preload();
    write_static_count(GLB);
    send_op(OP_PUSHC, -8388608);
    send_op(OP_PUSHC, 8388607);
    while (m_sp < STK) send_op(OP_PUSHC, int'($urandom_range(0, 24'hFFFFFF)));
    for (int i = 0; i < GLB; i++) send_op(OP_POPG, i);
    send_op(OP_DROP, m_sp);
  endtask

  task automatic test_directed();
    logic [7:0] ops[7] = '{OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LE, OP_GE};
    // most negative / -1 wraps, remainder 0
    send_op(OP_RDINT, 0, 32'h8000_0000);
    send_op(OP_PUSHC, -1);
    send_op(OP_DIV);
    send_op(OP_DUP);
    send_op(OP_PUSHC, -1);
    send_op(OP_MOD);
    send_op(OP_WRINT);
    send_op(OP_WRCHR);
    // remainder takes the sign of the dividend
    send_op(OP_PUSHC, -7);
    send_op(OP_PUSHC, 2);
    send_op(OP_MOD);
    send_op(OP_WRINT);
    // branch-if-true only on exactly 1; branch-if-false on 0
    send_op(OP_RDCHR, 0, 32'h1234_ABCD);
    send_op(OP_PUSHC, 8388607);
    send_op(OP_LT);
    send_op(OP_BRT, 100);
    send_op(OP_PUSHC, 2);
    send_op(OP_BRT, 300);
    send_op(OP_PUSHC, -8388608);
    send_op(OP_PUSHC, 7);
    send_op(OP_GT);
    send_op(OP_BRF, 200);
    foreach (ops[i]) begin
      send_op(OP_PUSHC, int'($urandom_range(0, 24'hFFFFFF)));
      send_op(OP_PUSHC, int'($urandom_range(0, 3)) - 1);
      send_op(ops[i]);
      send_op(OP_POPR);
    end
    send_op(OP_PUSHR);
    send_op(OP_WRINT);
    send_op(OP_CALL, 50);
    send_op(OP_RET);
    send_op(OP_ASF, 2);
    send_op(OP_PUSHL, -1);
    send_op(OP_POPL, 1);
    send_op(OP_RSF);
    send_op(OP_PUSHG, GLB - 1);
    send_op(OP_POPG, 0);
    send_op(OP_DROP, -3);
    send_op(OP_DROP, 0);
    send_op(OP_JMP, -1);
  endtask

  // One instruction that cannot fault from the current image.
  function automatic sme_in_t legal_word();
    sme_in_t w;
    int lim;
    bit ok;
    w.immediate = 24'($urandom_range(0, 24'hFFFFFF));
    w.read_value = $urandom;
    lim = (m_count < GLB) ? m_count : GLB;
    for (int tries = 0; tries < 40; tries++) begin
      w.func = 8'($urandom_range(1, 31));
      // lean towards popping once the depth passes 900, but let it wander
      if (m_sp > 900 && $urandom_range(1)) w.func = OP_POPR;
      case (w.func)
        OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR, OP_CALL: ok = m_sp < STK;
        OP_DUP: ok = m_sp >= 1 && m_sp < STK;
        OP_PUSHG: begin
          ok = m_sp < STK && lim > 0;
          if (ok) w.immediate = 24'($urandom_range(0, lim - 1));
        end
        OP_POPG: begin
          ok = m_sp >= 1 && lim > 0;
          if (ok) w.immediate = 24'($urandom_range(0, lim - 1));
        end
        OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: ok = m_sp >= 2;
        OP_DIV, OP_MOD: ok = m_sp >= 2 && stk_mem[m_sp-1] != 0;
        OP_WRINT, OP_WRCHR, OP_BRF, OP_BRT, OP_RET, OP_POPR: ok = m_sp >= 1;
        OP_ASF: begin
          w.immediate = 24'(int'($urandom_range(0, 6)) - int'($urandom_range(0, 2)));
          ok = m_sp < STK && m_sp + 1 + int'(w.immediate) >= 0 &&
               m_sp + 1 + int'(w.immediate) <= STK;
        end
        OP_RSF: ok = m_fp >= 1 && stk_mem[m_fp-1] <= STK;
        OP_PUSHL, OP_POPL: begin
          ok = (w.func == OP_PUSHL) ? (m_sp < STK) : (m_sp >= 1);
          w.immediate = 24'(int'($urandom_range(0, STK - 1)) - m_fp);
        end
        OP_DROP: begin
          w.immediate = 24'(($urandom_range(9) == 0) ? -int'($urandom_range(0, 5))
                                                      : int'($urandom_range(0, 3)));
          ok = int'(w.immediate) <= m_sp;
        end
        default: ok = 1'b1;  // jump
      endcase
      if (ok) return w;
    end
    w.func = OP_PUSHC;
    if (m_sp >= STK) begin
      w.func = OP_DROP;
      w.immediate = 24'd8;
    end
    return w;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_word(legal_word());
  endtask

  // Static count sweep with random programs; includes a no-stall stretch and a
  // pause until every outstanding result is back.
  task automatic test_random_phases();
    write_static_count(0);
    test_random(120);
    write_static_count(1);
    test_random(60);
    wait_drained();  // sender holds off until the result side is empty
    test_random(60);
    write_static_count(256);
    idle_en = 1'b0;
    test_random(120);
    idle_en = 1'b1;
    write_static_count(int'($urandom_range(2, 255)));
    test_random(100);
  endtask

  // The machine halts for good, so exactly one terminating case per run; the
  // seed picks which. Afterwards every word is answered as already halted.
  task automatic test_terminate();
    int pick;
    pick = $urandom_range(0, 6);
    if (m_sp > 0) send_op(OP_DROP, m_sp);
    case (pick)
      0: send_op(OP_HALT);
      1: begin
        // frame that fills the stack to the top, then one more push
        send_op(OP_ASF, STK - m_sp - 1);
        send_op(OP_PUSHC, 3);
      end
      2: send_op(OP_ADD);
      3: begin
        send_op(OP_PUSHC, 5);
        send_op(OP_PUSHC, 0);
        send_op(OP_DIV);
      end
      4: begin
        write_static_count(int'($urandom_range(0, 256)));
        send_op(OP_PUSHG, m_count);
      end
      5: send_op(OP_PUSHL, -m_fp - 1);
      default: send_op(8'($urandom_range(32, 255)), int'($urandom_range(0, 24'hFFFFFF)));
    endcase
    for (int i = 0; i < 24; i++)
      send_op(8'($urandom_range(0, 255)), int'($urandom_range(0, 24'hFFFFFF)), $urandom);
  endtask

  initial begin
    m_sp = 0; m_fp = 0; m_pc = '0; m_rv = '0; m_halt = 1'b0; m_count = 0;
    n_fail = 0; n_words = 0; n_results = 0; n_writes = 0; n_cfg = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_directed();
    test_random_phases();
    test_terminate();
    wait_drained();
    $display("Ran %0d instruction words (%0d results, %0d value writes) over %0d",
             n_words, n_results, n_writes, n_cfg);
    $display("static_count settings, ending in one halting case.");
    if (n_fail == 0) begin
      $display("stack_machine_execute verification clean");
    end else begin
      $display("stack_machine_execute verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/sme_pkg.sv
src/sme_ram.sv
src/sme_front.sv
src/sme_div.sv
src/sme_back.sv
src/stack_machine_execute.sv
tb/tb_stack_machine_execute.sv
